### src/packet_chunk_decoder_macros.svh
// Assertion macros shared by the packet chunk decoder.
`ifndef PACKET_CHUNK_DECODER_MACROS_SVH
`define PACKET_CHUNK_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packet chunk decoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packet chunk decoder: next-cycle check failed");

`endif

### src/pcd_pkg.sv
// Types, constants and the nibble character table of the packet chunk decoder.
package pcd_pkg;

	localparam logic [7:0] SEP_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE = 8'hD8;
	localparam logic [7:0] TEXT_XOR = 8'hFF;
	localparam int         NUM_FLAG_BIT = 7;
	localparam int         LEN_W = 7;

	typedef logic [LEN_W-1:0] len_t;

	typedef enum logic [1:0] {
		CMD_TEXT,
		CMD_NUM_PAIR,
		CMD_NUM_ONE,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] nib_char(input logic [3:0] nib);
		logic [7:0] ch;
		unique case (nib)
			4'h0: ch = 8'h00;
			4'h1: ch = 8'h20;
			4'h2: ch = 8'h2D;
			4'h3: ch = 8'h2E;
			4'h4: ch = 8'h30;
			4'h5: ch = 8'h31;
			4'h6: ch = 8'h32;
			4'h7: ch = 8'h33;
			4'h8: ch = 8'h34;
			4'h9: ch = 8'h35;
			4'hA: ch = 8'h36;
			4'hB: ch = 8'h37;
			4'hC: ch = 8'h38;
			4'hD: ch = 8'h39;
			4'hE: ch = 8'h0A;
			4'hF: ch = 8'h20;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

### src/pcd_intf.sv
// Valid/ready channel interfaces for packet bytes and decoded characters.
interface pcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       packet_start;

	modport source (output valid, output in_byte, output packet_start, input ready);
	modport sink (input valid, input in_byte, input packet_start, output ready);
endinterface

interface pcd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       packet_done;
	logic       last_of_item;

	modport source (output valid, output out_char, output packet_done, output last_of_item,
		input ready);
	modport sink (input valid, input out_char, input packet_done, input last_of_item,
		output ready);
endinterface

### src/pcd_front.sv
// Front end: tracks packet framing and turns each byte that yields output into a back-end command.
module pcd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	output logic           ready,
	input  logic [7:0]     in_byte,
	input  logic           packet_start,
	input  pcd_pkg::qstat_t qstat,
	output logic           push,
	output pcd_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_HEADER,
		PH_TEXT,
		PH_NUMBER
	} phase_t;

	phase_t         phase_q, phase_eff, phase_nx;
	pcd_pkg::len_t  count_q, count_eff, count_nx;
	logic           after_q, after_eff, after_nx;
	logic           accept;
	pcd_pkg::len_t  hdr_len;

	assign ready   = !qstat.full;
	assign accept  = valid && ready;
	assign hdr_len = in_byte[pcd_pkg::LEN_W-1:0];

	always_comb begin
		// a packet start restarts the seek on this very byte
		phase_eff = packet_start ? PH_SEEK : phase_q;
		count_eff = packet_start ? '0 : count_q;
		after_eff = packet_start ? 1'b0 : after_q;

		phase_nx = phase_eff;
		count_nx = count_eff;
		after_nx = after_eff;
		push     = 1'b0;
		cmd.kind = pcd_pkg::CMD_TEXT;
		cmd.data = in_byte;

		unique case (phase_eff)
			PH_SEEK: begin
				if (in_byte == pcd_pkg::SEP_BYTE) begin
					phase_nx = PH_HEADER;
					after_nx = 1'b0;
				end
			end
			PH_HEADER: begin
				priority if (after_eff && in_byte == pcd_pkg::END_BYTE) begin
					push     = 1'b1;
					cmd.kind = pcd_pkg::CMD_END;
					phase_nx = PH_SEEK;
					after_nx = 1'b0;
					count_nx = '0;
				end else if (in_byte == pcd_pkg::SEP_BYTE) begin
					after_nx = 1'b0;
				end else begin
					count_nx = hdr_len;
					if (hdr_len == '0) begin
						after_nx = 1'b1;
					end else begin
						after_nx = 1'b0;
						phase_nx = in_byte[pcd_pkg::NUM_FLAG_BIT] ? PH_NUMBER : PH_TEXT;
					end
				end
			end
			PH_TEXT: begin
				push     = 1'b1;
				cmd.kind = pcd_pkg::CMD_TEXT;
				count_nx = count_eff - pcd_pkg::LEN_W'(1);
				if (count_eff <= pcd_pkg::LEN_W'(1)) begin
					count_nx = '0;
					phase_nx = PH_HEADER;
					after_nx = 1'b1;
				end
			end
			PH_NUMBER: begin
				push = 1'b1;
				if (count_eff >= pcd_pkg::LEN_W'(2)) begin
					cmd.kind = pcd_pkg::CMD_NUM_PAIR;
					count_nx = count_eff - pcd_pkg::LEN_W'(2);
					if (count_eff == pcd_pkg::LEN_W'(2)) begin
						phase_nx = PH_HEADER;
						after_nx = 1'b1;
					end
				end else begin
					// odd count: the low nibble of the last byte is dropped
					cmd.kind = pcd_pkg::CMD_NUM_ONE;
					count_nx = '0;
					phase_nx = PH_HEADER;
					after_nx = 1'b1;
				end
			end
			default: phase_nx = PH_SEEK;
		endcase

		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			count_q <= '0;
			after_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nx;
			count_q <= count_nx;
			after_q <= after_nx;
		end
	end

endmodule

### src/pcd_queue.sv
// Command queue between the front and back ends.
module pcd_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcd_pkg::cmd_t   wr_cmd,
	input  logic            pop,
	output pcd_pkg::cmd_t   rd_cmd,
	output pcd_pkg::qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcd_pkg::cmd_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### src/pcd_back.sv
// Back end: expands queued commands into characters behind an output register.
module pcd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pcd_pkg::cmd_t   cmd,
	input  pcd_pkg::qstat_t qstat,
	output logic            pop,
	output logic            valid,
	input  logic            ready,
	output logic [7:0]      out_char,
	output logic            packet_done,
	output logic            last_of_item
);

	logic       valid_q;
	logic [7:0] char_q;
	logic       done_q;
	logic       last_q;
	logic       pend_q;
	logic [3:0] low_nib_q;
	logic       load;

	assign valid        = valid_q;
	assign out_char     = char_q;
	assign packet_done  = done_q;
	assign last_of_item = last_q;

	// the output register may refill when empty or when its transfer completes
	assign load = !valid_q || ready;
	assign pop  = load && !pend_q && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !qstat.empty;
				pend_q  <= !qstat.empty && (cmd.kind == pcd_pkg::CMD_NUM_PAIR);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				char_q <= pcd_pkg::nib_char(low_nib_q);
				done_q <= 1'b0;
				last_q <= 1'b1;
			end else begin
				low_nib_q <= cmd.data[3:0];
				unique case (cmd.kind)
					pcd_pkg::CMD_TEXT: begin
						char_q <= cmd.data ^ pcd_pkg::TEXT_XOR;
						done_q <= 1'b0;
						last_q <= 1'b1;
					end
					pcd_pkg::CMD_NUM_PAIR: begin
						char_q <= pcd_pkg::nib_char(cmd.data[7:4]);
						done_q <= 1'b0;
						last_q <= 1'b0;
					end
					pcd_pkg::CMD_NUM_ONE: begin
						char_q <= pcd_pkg::nib_char(cmd.data[7:4]);
						done_q <= 1'b0;
						last_q <= 1'b1;
					end
					pcd_pkg::CMD_END: begin
						char_q <= '0;
						done_q <= 1'b1;
						last_q <= 1'b1;
					end
					default: begin
						char_q <= '0;
						done_q <= 1'b0;
						last_q <= 1'b1;
					end
				endcase
			end
		end
	end

endmodule

### src/packet_chunk_decoder.sv
// Packet chunk decoder: received packet bytes in, decoded characters out.
//
// byte_ch carries one received byte per transfer, with packet_start high on
// the first byte of a packet. char_ch carries decoded characters; packet_done
// marks the end result of a packet and last_of_item the final character that
// one input byte produced.
// A front end follows the framing (seek to 0xFF, chunk headers, runs) and
// queues one command per byte that yields output. A back end expands each
// command behind an output register: text bytes and end markers give one
// result, number bytes give one or two nibble characters.
// With the queue empty, the first result of a byte reaches char_ch through the
// queue write and then the output register.
// Throughput: one byte per cycle for skipped and text bytes while the queue has
// room; a number byte holding two nibbles keeps the output register busy for
// both of its characters, so a number run falls below that rate.
// When the receiver stalls, the output register holds its result and the
// command queue (QUEUE_DEPTH entries) fills; byte_ch then drops ready.
// Reset empties the queue and output register and returns to seeking 0xFF.
`include "packet_chunk_decoder_macros.svh"

module packet_chunk_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic        clk,
	input logic        arst_n,
	pcd_byte_if.sink   byte_ch,
	pcd_char_if.source char_ch
);

	pcd_pkg::cmd_t   push_cmd;
	pcd_pkg::cmd_t   head_cmd;
	pcd_pkg::qstat_t qstat;
	logic            push;
	logic            pop;
	logic            out_fire;
	logic            out_end;
	logic            out_tail;

	pcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (byte_ch.valid),
		.ready        (byte_ch.ready),
		.in_byte      (byte_ch.in_byte),
		.packet_start (byte_ch.packet_start),
		.qstat        (qstat),
		.push         (push),
		.cmd          (push_cmd)
	);

	pcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.qstat  (qstat)
	);

	pcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head_cmd),
		.qstat        (qstat),
		.pop          (pop),
		.valid        (char_ch.valid),
		.ready        (char_ch.ready),
		.out_char     (char_ch.out_char),
		.packet_done  (char_ch.packet_done),
		.last_of_item (char_ch.last_of_item)
	);

	assign out_fire = char_ch.valid && char_ch.ready;
	assign out_end  = char_ch.valid && char_ch.packet_done;
	assign out_tail = char_ch.valid && char_ch.last_of_item && !char_ch.packet_done;

	`PCD_ASSERT_NOW(a_push_not_full, push, !qstat.full)
	`PCD_ASSERT_NOW(a_pop_not_empty, pop, !qstat.empty)
	`PCD_ASSERT_NOW(a_end_result_form, out_end, char_ch.out_char == 8'h00 && char_ch.last_of_item)
	`PCD_ASSERT_NEXT(a_pair_tail_follows, out_fire && !char_ch.last_of_item, out_tail)

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the packet chunk decoder: directed table, then random packets and noise bytes.
module testbench;

	localparam int ITEM_TARGET    = 1700;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 16;

	typedef enum logic [1:0] {
		PH_SEEK,
		PH_HEADER,
		PH_TEXT,
		PH_NUMBER
	} dec_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       done;
		logic       last;
	} char_res_t;

	typedef struct {
		logic [7:0] pkt_byte;
		logic       pkt_first;
		bit         typed;
		int         n;
		char_res_t  r0;
		char_res_t  r1;
	} stim_row_t;

	localparam char_res_t NO_RES  = '0;
	localparam char_res_t END_RES = '{8'h00, 1'b1, 1'b1};

	localparam logic [7:0] NIB_GLYPH [16] = '{
		8'h00, 8'h20, 8'h2D, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33,
		8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h0A, 8'h20
	};

	logic clk;
	logic arst_n;

	pcd_byte_if byte_ch ();
	pcd_char_if char_ch ();

	packet_chunk_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.char_ch (char_ch)
	);

	// decoder state as the testbench tracks it
	dec_phase_t dec_phase    = PH_SEEK;
	logic [6:0] run_bytes    = '0;
	logic [6:0] run_nibbles  = '0;
	logic       chunk_closed = 1'b0;

	char_res_t char_expect [$];
	int        errors       = 0;
	int        worked_items = 0;
	int        quiet_cycles = 0;
	int        src_idle_pct = 0;
	int        sink_idle_pct = 0;

	stim_row_t dir_rows [25] = '{
		'{8'h41, 1'b1, 1'b1, 0, NO_RES, NO_RES},
		'{8'h00, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'h00, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'hD8, 1'b0, 1'b1, 1, END_RES, NO_RES},
		'{8'hD8, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'h80, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'h81, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'hFF, 1'b0, 1'b0, 0, NO_RES, NO_RES},
		'{8'h02, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1, '{8'hFF, 1'b0, 1'b1}, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 1, '{8'h00, 1'b0, 1'b1}, NO_RES},
		'{8'h84, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'h01, 1'b0, 1'b0, 0, NO_RES, NO_RES},
		'{8'hEF, 1'b0, 1'b0, 0, NO_RES, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'hD8, 1'b0, 1'b0, 0, NO_RES, NO_RES},
		'{8'h23, 1'b0, 1'b0, 0, NO_RES, NO_RES},
		'{8'h45, 1'b1, 1'b1, 0, NO_RES, NO_RES},
		'{8'hFF, 1'b1, 1'b1, 0, NO_RES, NO_RES},
		'{8'h01, 1'b0, 1'b1, 0, NO_RES, NO_RES},
		'{8'h80, 1'b0, 1'b1, 1, '{8'h7F, 1'b0, 1'b1}, NO_RES},
		'{8'hD8, 1'b0, 1'b1, 1, END_RES, NO_RES}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Decode one byte: returns the number of characters it yields.
	function automatic int decode_byte(input logic [7:0] b, input logic first,
			output char_res_t r0, output char_res_t r1);
		int         n;
		logic [6:0] len;
		n = 0;
		r0 = NO_RES;
		r1 = NO_RES;
		len = b[6:0];
		if (first) begin
			dec_phase = PH_SEEK;
			run_bytes = '0;
			run_nibbles = '0;
			chunk_closed = 1'b0;
		end
		case (dec_phase)
			PH_SEEK: begin
				if (b == pcd_pkg::SEP_BYTE) begin
					dec_phase = PH_HEADER;
					chunk_closed = 1'b0;
				end
			end
			PH_HEADER: begin
				if (chunk_closed && b == pcd_pkg::END_BYTE) begin
					r0 = END_RES;
					n = 1;
					dec_phase = PH_SEEK;
					chunk_closed = 1'b0;
					run_bytes = '0;
					run_nibbles = '0;
				end else if (b == pcd_pkg::SEP_BYTE) begin
					chunk_closed = 1'b0;
				end else if (!b[pcd_pkg::NUM_FLAG_BIT]) begin
					run_bytes = len;
					chunk_closed = (len == 0);
					if (len != 0)
						dec_phase = PH_TEXT;
				end else begin
					run_nibbles = len;
					chunk_closed = (len == 0);
					if (len != 0)
						dec_phase = PH_NUMBER;
				end
			end
			PH_TEXT: begin
				r0 = '{b ^ pcd_pkg::TEXT_XOR, 1'b0, 1'b1};
				n = 1;
				if (run_bytes != 0)
					run_bytes = run_bytes - 7'd1;
				if (run_bytes == 0) begin
					dec_phase = PH_HEADER;
					chunk_closed = 1'b1;
				end
			end
			default: begin
				if (run_nibbles >= 2) begin
					r0 = '{NIB_GLYPH[b[7:4]], 1'b0, 1'b0};
					r1 = '{NIB_GLYPH[b[3:0]], 1'b0, 1'b1};
					n = 2;
					run_nibbles = run_nibbles - 7'd2;
				end else begin
					// odd count: low nibble dropped
					r0 = '{NIB_GLYPH[b[7:4]], 1'b0, 1'b1};
					n = 1;
					run_nibbles = '0;
				end
				if (run_nibbles == 0) begin
					dec_phase = PH_HEADER;
					chunk_closed = 1'b1;
				end
			end
		endcase
		return n;
	endfunction

	// Offer one byte, hold it until the transfer, then record what it yields if predicted.
	task automatic send_byte(input logic [7:0] b, input logic first, input bit predicted);
		char_res_t r0;
		char_res_t r1;
		int        n;
		if ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.packet_start <= first;
		do @(posedge clk); while (!byte_ch.ready);
		n = decode_byte(b, first, r0, r1);
		if (predicted && n > 0)
			char_expect.push_back(r0);
		if (predicted && n > 1)
			char_expect.push_back(r1);
		worked_items++;
	endtask

	task automatic drain_results;
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (char_expect.size() != 0);
	endtask

	// Well-formed packet with random content, now and then cut short.
	task automatic send_packet;
		int         junk;
		int         chunks;
		int         len;
		int         nbytes;
		int         r;
		logic [7:0] hdr;
		junk = $urandom_range(0, 2);
		for (int i = 0; i < junk; i++)
			send_byte(8'($urandom_range(0, 254)), i == 0, 1'b1);
		send_byte(pcd_pkg::SEP_BYTE, junk == 0, 1'b1);
		chunks = $urandom_range(1, 4);
		for (int c = 0; c < chunks; c++) begin
			if ($urandom_range(5) == 0)
				send_byte(pcd_pkg::SEP_BYTE, 1'b0, 1'b1);
			r = $urandom_range(99);
			if (r < 8)
				len = 0;
			else if (r < 88)
				len = $urandom_range(1, 10);
			else if (r < 97)
				len = $urandom_range(11, 40);
			else
				len = $urandom_range(100, 127);
			hdr = {1'($urandom_range(1)), 7'(len)};
			if (hdr == pcd_pkg::SEP_BYTE)
				hdr = 8'hFE;
			send_byte(hdr, 1'b0, 1'b1);
			nbytes = hdr[pcd_pkg::NUM_FLAG_BIT] ? (int'(hdr[6:0]) + 1) / 2 : int'(hdr[6:0]);
			if ($urandom_range(11) == 0)
				nbytes = $urandom_range(0, nbytes);
			for (int k = 0; k < nbytes; k++)
				send_byte(($urandom_range(15) == 0) ? pcd_pkg::SEP_BYTE
					: 8'($urandom_range(255)), 1'b0, 1'b1);
		end
		if ($urandom_range(99) < 85)
			send_byte(pcd_pkg::END_BYTE, 1'b0, 1'b1);
		repeat ($urandom_range(0, 1))
			send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Loose bytes, biased towards separators and end markers.
	task automatic send_noise;
		int         r;
		logic [7:0] b;
		repeat ($urandom_range(3, 12)) begin
			r = $urandom_range(5);
			b = (r == 0) ? pcd_pkg::SEP_BYTE
				: (r == 1) ? pcd_pkg::END_BYTE : 8'($urandom_range(255));
			send_byte(b, $urandom_range(9) == 0, 1'b1);
		end
	endtask

	always @(posedge clk)
		char_ch.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		char_res_t want;
		if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (char_expect.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual char %h done %b last %b",
					$time, char_ch.out_char, char_ch.packet_done, char_ch.last_of_item);
				errors++;
			end else begin
				want = char_expect.pop_front();
				if (want.ch !== char_ch.out_char) begin
					$display("%0t: out_char expected %h actual %h",
						$time, want.ch, char_ch.out_char);
					errors++;
				end
				if (want.done !== char_ch.packet_done) begin
					$display("%0t: packet_done expected %b actual %b",
						$time, want.done, char_ch.packet_done);
					errors++;
				end
				if (want.last !== char_ch.last_of_item) begin
					$display("%0t: last_of_item expected %b actual %b",
						$time, want.last, char_ch.last_of_item);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int stage;
		stage = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		byte_ch.packet_start = 1'b0;
		char_ch.ready = 1'b0;
		src_idle_pct = 25;
		sink_idle_pct = 72;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].pkt_byte, dir_rows[i].pkt_first, !dir_rows[i].typed);
			if (dir_rows[i].typed && dir_rows[i].n > 0)
				char_expect.push_back(dir_rows[i].r0);
			if (dir_rows[i].typed && dir_rows[i].n > 1)
				char_expect.push_back(dir_rows[i].r1);
		end

		while (worked_items < ITEM_TARGET) begin
			// swap the idling sides, then run with none
			if (stage == 0 && worked_items >= ITEM_TARGET / 3) begin
				drain_results();
				stage = 1;
				src_idle_pct = 72;
				sink_idle_pct = 25;
			end else if (stage == 1 && worked_items >= 2 * ITEM_TARGET / 3) begin
				drain_results();
				stage = 2;
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if ($urandom_range(7) == 0)
				send_noise();
			else
				send_packet();
			if ($urandom_range(14) == 0)
				drain_results();
		end

		byte_ch.valid <= 1'b0;
		while (char_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
